// ----- rtl/cft_pkg.sv -----
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and constants of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package cft_pkg;

  // field length cap and field count limit
  localparam int unsigned FieldLen  = 256;
  localparam int unsigned MaxFields = 256;

  // width of the per-field fill counter, it holds up to FieldLen-1
  localparam int unsigned FillW = $clog2(FieldLen);
  localparam logic [FillW-1:0] FillMax = FillW'(FieldLen - 1);

  // field index stops at the smaller of MaxFields-1 and 255
  localparam int unsigned FieldCapInt = (MaxFields - 1 < 255) ? (MaxFields - 1) : 255;
  localparam logic [7:0]  FieldCap    = 8'(FieldCapInt);

  // token queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // character codes
  localparam logic [7:0] QuoteCh   = 8'h22;
  localparam logic [7:0] NewlineCh = 8'h0A;
  localparam logic [7:0] SpaceCh   = 8'h20;
  localparam logic [7:0] TabCh     = 8'h09;
  localparam logic [7:0] SepReset  = 8'h2C;

  // byte classes handed from front to back
  typedef enum logic [2:0] {
    TokNone = 3'd0,
    TokData = 3'd1,
    TokLitq = 3'd2,
    TokSep  = 3'd3,
    TokEol  = 3'd4
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] data;
    logic       fin;
  } tok_t;

  // one result item
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  out_byte;
    logic        end_of_field;
    logic        end_of_record;
    logic [7:0]  field_index;
    logic [31:0] record_index;
    logic        truncated;
  } res_t;

  // queue to back handshake
  typedef struct packed {
    logic valid;
    tok_t tok;
  } q_out_t;

endpackage

// ----- rtl/cft_front.sv -----
// ----------------------------------------------------------------------------
// cft_front
// Quote tracking and byte classification; pushes tokens into the queue.
// ----------------------------------------------------------------------------
module cft_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              final_req_i,
  input  logic [7:0]        separator_i,
  output logic              push_o,
  output cft_pkg::tok_t     tok_o
);
  import cft_pkg::*;

  logic      in_quotes_q, in_quotes_d;
  logic      quote_pend_q, quote_pend_d;
  logic      iq_eff;
  tok_kind_e kind;

  // classify against the quote state in effect for this byte
  always_comb begin
    in_quotes_d  = in_quotes_q;
    quote_pend_d = 1'b0;
    iq_eff       = in_quotes_q;
    kind         = TokData;
    if (quote_pend_q && data_byte_i == QuoteCh) begin
      kind = TokLitq;
    end else if (!quote_pend_q && data_byte_i == QuoteCh) begin
      quote_pend_d = 1'b1;
      kind         = TokNone;
    end else begin
      if (quote_pend_q) begin
        iq_eff      = !in_quotes_q;
        in_quotes_d = !in_quotes_q;
      end
      if (!iq_eff && data_byte_i == NewlineCh) begin
        kind = TokEol;
      end else if (!iq_eff && data_byte_i == separator_i) begin
        kind = TokSep;
      end else begin
        kind = TokData;
      end
    end
  end

  assign tok_o.kind = kind;
  assign tok_o.data = data_byte_i;
  assign tok_o.fin  = final_req_i;
  assign push_o     = accept_i && (kind != TokNone || final_req_i);

  // quote state, cleared by a final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quotes_q  <= 1'b0;
      quote_pend_q <= 1'b0;
    end else if (accept_i) begin
      if (final_req_i) begin
        in_quotes_q  <= 1'b0;
        quote_pend_q <= 1'b0;
      end else begin
        in_quotes_q  <= in_quotes_d;
        quote_pend_q <= quote_pend_d;
      end
    end
  end

endmodule

// ----- rtl/cft_queue.sv -----
// ----------------------------------------------------------------------------
// cft_queue
// Short token queue that lets front and back stall independently.
// ----------------------------------------------------------------------------
module cft_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cft_pkg::tok_t     tok_i,
  output logic              full_o,
  input  logic              pop_i,
  output cft_pkg::q_out_t   q_o
);
  import cft_pkg::*;

  tok_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o   = (cnt_q == QCntW'(QueueDepth));
  assign q_o.valid = (cnt_q != '0);
  assign q_o.tok   = mem_q[rd_ptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && q_o.valid;

  // pointer and count update with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // token storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

endmodule

// ----- rtl/cft_back.sv -----
// ----------------------------------------------------------------------------
// cft_back
// Field and record bookkeeping; builds result items into an output register.
// ----------------------------------------------------------------------------
module cft_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cft_pkg::q_out_t   q_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cft_pkg::res_t     res_o
);
  import cft_pkg::*;

  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       field_num_q, field_num_d;
  logic [31:0]      record_num_q, record_num_d;
  logic             ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  logic             load, content, drop_ws, at_cap, has, ovf_new, emit, is_sep, is_eol;
  tok_t             tok;

  assign tok     = q_i.tok;
  assign load    = !out_valid_q || !out_stall_i;
  assign pop_o   = q_i.valid && load;

  // per-token decisions
  always_comb begin
    is_sep  = (tok.kind == TokSep);
    is_eol  = (tok.kind == TokEol);
    content = (tok.kind == TokData) || (tok.kind == TokLitq);
    drop_ws = (tok.kind == TokData) && (fill_q == '0) &&
              (tok.data == SpaceCh || tok.data == TabCh);
    at_cap  = (fill_q >= FillMax);
    has     = content && !drop_ws && !at_cap;
    ovf_new = ovf_q || (content && !drop_ws && at_cap);
    emit    = has || is_sep || is_eol || tok.fin;

    res_d.has_byte      = has;
    res_d.out_byte      = has ? tok.data : 8'h00;
    res_d.end_of_field  = is_sep || is_eol || tok.fin;
    res_d.end_of_record = is_eol || tok.fin;
    res_d.field_index   = field_num_q;
    res_d.record_index  = record_num_q;
    res_d.truncated     = ovf_new;
  end

  // stream state update
  always_comb begin
    fill_d       = fill_q;
    field_num_d  = field_num_q;
    record_num_d = record_num_q;
    ovf_d        = ovf_q;
    if (tok.fin) begin
      fill_d       = '0;
      field_num_d  = '0;
      record_num_d = '0;
      ovf_d        = 1'b0;
    end else if (is_sep) begin
      fill_d = '0;
      ovf_d  = 1'b0;
      if (field_num_q < FieldCap) begin
        field_num_d = field_num_q + 8'd1;
      end
    end else if (is_eol) begin
      fill_d      = '0;
      ovf_d       = 1'b0;
      field_num_d = '0;
      if (record_num_q != 32'hFFFF_FFFF) begin
        record_num_d = record_num_q + 32'd1;
      end
    end else begin
      ovf_d = ovf_new;
      if (has) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  assign out_valid_d = load ? (pop_o && emit) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      field_num_q  <= '0;
      record_num_q <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        fill_q       <= fill_d;
        field_num_q  <= field_num_d;
        record_num_q <= record_num_d;
        ovf_q        <= ovf_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/csv_field_tokenizer.sv -----
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Splits a CSV byte stream into fields and records, one byte per transaction.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o  data_byte_i, final_req_i
//   out      source     out_valid_o/out_stall_i has_byte_o .. truncated_o
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_data_i (separator)
//
// One byte per cycle sustained while out is not stalled; a result passes
// through front classification, a queue slot and the back output register.
// Reset clears quote state, counters and queue; separator returns to comma.
// A stall on out fills the two-entry token queue, then raises in_stall_o.
// A held quote is not queued unless it is the final byte; other bytes that
// give no result (leading blanks, capped bytes) still pass through the queue
// and are each popped by the back.
// ----------------------------------------------------------------------------
module csv_field_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        has_byte_o,
  output logic [7:0]  out_byte_o,
  output logic        end_of_field_o,
  output logic        end_of_record_o,
  output logic [7:0]  field_index_o,
  output logic [31:0] record_index_o,
  output logic        truncated_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  import cft_pkg::*;

  logic [7:0] separator_q;
  logic       in_accept, push, full, pop;
  tok_t       tok;
  q_out_t     q_out;
  res_t       res;

  // separator register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      separator_q <= SepReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      separator_q <= cfg_data_i;
    end
  end

  assign in_stall_o = full;
  assign in_accept  = in_valid_i && !in_stall_o;

  cft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (data_byte_i),
    .final_req_i (final_req_i),
    .separator_i (separator_q),
    .push_o      (push),
    .tok_o       (tok)
  );

  cft_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .tok_i  (tok),
    .full_o (full),
    .pop_i  (pop),
    .q_o    (q_out)
  );

  cft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_i         (q_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  // result fields
  assign has_byte_o      = res.has_byte;
  assign out_byte_o      = res.out_byte;
  assign end_of_field_o  = res.end_of_field;
  assign end_of_record_o = res.end_of_record;
  assign field_index_o   = res.field_index;
  assign record_index_o  = res.record_index;
  assign truncated_o     = res.truncated;

endmodule
